// ===== rtl/prd_pkg.sv =====
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants for the pooled random range draw block.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

    localparam int WORD_W  = 32;
    localparam int RANGE_W = 16;
    localparam int ADDR_W  = 9;
    localparam int KIND_W  = 2;
    localparam int DATA_W  = 64;

    // exponent of the search base once 32*n is folded into it (2^31 / 32)
    localparam int BASE_LOG = 26;
    localparam int BASE_W   = BASE_LOG + 1;
    localparam int SHIFT_W  = 5;
    localparam int CNT_W    = 5;

    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SETPOS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd2;

    // request into the reduction engine
    typedef struct packed {
        logic               start;
        logic [RANGE_W-1:0] n;
        logic [WORD_W-1:0]  word;
    } prd_req_t;

    // response from the reduction engine
    typedef struct packed {
        logic               done;
        logic [RANGE_W-1:0] value;
    } prd_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/prd_reduce.sv =====
// ----------------------------------------------------------------------------
// prd_reduce
// Range reduction of one pool word: serial n*n, power-of-two factor search,
// then a bit-serial restoring modulo by n over the kept word bits.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_reduce
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire prd_pkg::prd_req_t req,
    output      prd_pkg::prd_rsp_t rsp
);

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_SQ   = 4'b0010,
        E_SRCH = 4'b0100,
        E_DIV  = 4'b1000
    } eng_state_t;

    eng_state_t                       state_reg, state_next;
    logic                             done_reg, done_next;
    logic [prd_pkg::RANGE_W-1:0]      n_reg, n_next;
    logic [prd_pkg::WORD_W-1:0]       word_reg, word_next;
    logic [prd_pkg::WORD_W-1:0]       acc_reg, acc_next;
    logic [prd_pkg::WORD_W-1:0]       madd_reg, madd_next;
    logic [prd_pkg::RANGE_W-1:0]      mplier_reg, mplier_next;
    logic [prd_pkg::BASE_W-1:0]       base_reg, base_next;
    logic [prd_pkg::SHIFT_W-1:0]      k_reg, k_next;
    logic [prd_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [prd_pkg::RANGE_W-1:0]      rem_reg, rem_next;
    logic [prd_pkg::RANGE_W:0]        trial;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        n_next      = n_reg;
        word_next   = word_reg;
        acc_next    = acc_reg;
        madd_next   = madd_reg;
        mplier_next = mplier_reg;
        base_next   = base_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        trial       = {rem_reg, word_reg[prd_pkg::WORD_W-1]};

        case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    n_next      = req.n;
                    word_next   = req.word;
                    acc_next    = '0;
                    madd_next   = {{(prd_pkg::WORD_W-prd_pkg::RANGE_W){1'b0}}, req.n};
                    mplier_next = req.n;
                    cnt_next    = prd_pkg::CNT_W'(prd_pkg::RANGE_W - 1);
                    state_next  = E_SQ;
                end
            end
            E_SQ:
            begin
                // shift-add square, one multiplier bit a cycle
                if (mplier_reg[0])
                    acc_next = acc_reg + madd_reg;
                madd_next   = {madd_reg[prd_pkg::WORD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[prd_pkg::RANGE_W-1:1]};
                if (cnt_reg == '0)
                begin
                    base_next  = prd_pkg::BASE_W'(1) << prd_pkg::BASE_LOG;
                    k_next     = '0;
                    state_next = E_SRCH;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            E_SRCH:
            begin
                // halve while 2^(26-k) >= n*n
                if ({{(prd_pkg::WORD_W-prd_pkg::BASE_W){1'b0}}, base_reg} >= acc_reg)
                begin
                    base_next = {1'b0, base_reg[prd_pkg::BASE_W-1:1]};
                    k_next    = k_reg + 1'b1;
                end
                else
                begin
                    // keep word bits 31 down to k+1
                    cnt_next   = prd_pkg::CNT_W'(prd_pkg::WORD_W - 1) - k_reg;
                    rem_next   = '0;
                    state_next = E_DIV;
                end
            end
            E_DIV:
            begin
                if (trial >= {1'b0, n_reg})
                    rem_next = prd_pkg::RANGE_W'(trial - {1'b0, n_reg});
                else
                    rem_next = trial[prd_pkg::RANGE_W-1:0];
                word_next = {word_reg[prd_pkg::WORD_W-2:0], 1'b0};
                if (cnt_reg == prd_pkg::CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        word_reg   <= word_next;
        acc_reg    <= acc_next;
        madd_reg   <= madd_next;
        mplier_reg <= mplier_next;
        base_reg   <= base_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/pooled_random_range_draw.sv =====
// ----------------------------------------------------------------------------
// pooled_random_range_draw
// Pool of random words with a read position; draws a value in 0..n-1.
// ----------------------------------------------------------------------------
// Pool write and read-position set: next word taken at once.
// Draw with n >= 2: pool read, 16 squaring steps, factor-search plus modulo
// steps always 32, then handoff; no new word is taken until the result is pushed.
// Draw with n < 2: no pool read; the result goes out through the push state.
// One draw in flight; the output register holds a result while writes go on.
// Reset clears control state and the read position; pool contents are kept.
`default_nettype none

module pooled_random_range_draw
#(
    parameter int POOL_DEPTH = 512
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    // address [8:0], word [40:9], range [56:41], zero [63:57]
    input  wire logic [prd_pkg::DATA_W-1:0]   s_tdata,
    // kind [1:0]
    input  wire logic [prd_pkg::KIND_W-1:0]   s_tuser,
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    // value [15:0]
    output      logic [prd_pkg::RANGE_W-1:0]  m_tdata
);

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int PW = $clog2(POOL_DEPTH + 1);
    localparam int XW = (PW > prd_pkg::ADDR_W) ? PW : prd_pkg::ADDR_W;

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_READ = 4'b0010,
        T_CALC = 4'b0100,
        T_PUSH = 4'b1000
    } top_state_t;

    top_state_t                   state_reg, state_next;
    logic [XW-1:0]                rd_pos_reg, rd_pos_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [prd_pkg::RANGE_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [prd_pkg::RANGE_W-1:0]  pend_reg, pend_next;
    logic [prd_pkg::RANGE_W-1:0]  range_reg, range_next;

    logic [prd_pkg::WORD_W-1:0]   pool_mem [POOL_DEPTH];
    logic [prd_pkg::WORD_W-1:0]   rd_data_reg;

    logic [prd_pkg::ADDR_W-1:0]   in_address;
    logic [prd_pkg::WORD_W-1:0]   in_word;
    logic [prd_pkg::RANGE_W-1:0]  in_range;
    logic [XW-1:0]                addr_x;
    logic [XW-1:0]                pos_wrap;
    logic                         accept;
    logic                         wr_en;

    prd_pkg::prd_req_t            eng_req;
    prd_pkg::prd_rsp_t            eng_rsp;

    assign in_address = s_tdata[prd_pkg::ADDR_W-1:0];
    assign in_word    = s_tdata[prd_pkg::ADDR_W +: prd_pkg::WORD_W];
    assign in_range   = s_tdata[prd_pkg::ADDR_W + prd_pkg::WORD_W +: prd_pkg::RANGE_W];

    assign addr_x   = XW'(in_address);
    assign pos_wrap = (rd_pos_reg >= XW'(POOL_DEPTH)) ? '0 : rd_pos_reg;
    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_tuser == prd_pkg::KIND_WRITE)
                      && (addr_x < XW'(POOL_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            pool_mem[addr_x[AW-1:0]] <= in_word;
        rd_data_reg <= pool_mem[pos_wrap[AW-1:0]];
    end

    always_comb
    begin
        state_next    = state_reg;
        rd_pos_next   = rd_pos_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        pend_next     = pend_reg;
        range_next    = range_reg;
        eng_req.start = 1'b0;
        eng_req.n     = range_reg;
        eng_req.word  = rd_data_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        prd_pkg::KIND_SETPOS:
                        begin
                            rd_pos_next = addr_x;
                        end
                        prd_pkg::KIND_DRAW:
                        begin
                            if (in_range < prd_pkg::RANGE_W'(2))
                            begin
                                pend_next  = '0;
                                state_next = T_PUSH;
                            end
                            else
                            begin
                                // pool read issued this cycle at pos_wrap
                                rd_pos_next = pos_wrap + 1'b1;
                                range_next  = in_range;
                                state_next  = T_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            T_READ:
            begin
                eng_req.start = 1'b1;
                state_next    = T_CALC;
            end
            T_CALC:
            begin
                if (eng_rsp.done)
                begin
                    pend_next  = eng_rsp.value;
                    state_next = T_PUSH;
                end
            end
            T_PUSH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pend_reg;
                    state_next    = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            rd_pos_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_pos_reg   <= rd_pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        pend_reg    <= pend_next;
        range_reg   <= range_next;
    end

    prd_reduce u_reduce
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eng_req),
        .rsp   (eng_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
